@@ sv/gsco_pkg.sv @@
// Package for the greedy segment chain orderer.
// Holds shared constants and types; depends on nothing.
package gsco_pkg;

    localparam int MAX_SEGMENTS_DEF = 64;
    localparam int COORD_BITS_DEF   = 20;
    localparam int INDEX_BITS       = 6;
    localparam int ACTION_BITS      = 2;

    // Orientation actions, in pairing priority order.
    localparam logic [1:0] ACT_NONE      = 2'd0;
    localparam logic [1:0] ACT_REV_CHAIN = 2'd1;
    localparam logic [1:0] ACT_REV_ADDED = 2'd2;
    localparam logic [1:0] ACT_REV_BOTH  = 2'd3;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_EMIT
    } state_t;

endpackage

@@ sv/greedy_segment_chain_orderer.sv @@
// Greedy segment chain orderer, top level.
// Segments are accepted while loading; on the last segment, each chain step scans
// the remaining cells one pairing-axis at a time, and results leave one per step.
// Reset (rst_n, asynchronous, active low) empties the set and clears control.
// Stored segments are not cleared; they are overwritten on load.
module greedy_segment_chain_orderer
    import gsco_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    parameter int COORD_BITS   = COORD_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] start_z,
    input  logic signed [COORD_BITS-1:0] finish_x,
    input  logic signed [COORD_BITS-1:0] finish_y,
    input  logic signed [COORD_BITS-1:0] finish_z,
    input  logic                         last_segment,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [INDEX_BITS-1:0]        segment_index,
    output logic [ACTION_BITS-1:0]       orient_action,
    output logic                         dropped_flag,
    output logic                         chain_done
);

    localparam int CB   = COORD_BITS;
    localparam int PW   = 3*CB;
    localparam int SB   = $clog2(MAX_SEGMENTS);
    localparam int CNTB = $clog2(MAX_SEGMENTS+1);
    localparam int DW   = 2*CB+3;

    // Row of cells. Slot 0 is the scan head; the row rotates left one cell per
    // candidate so the cell at slot 0 is always the one being compared.
    logic [PW-1:0]         cell_start [MAX_SEGMENTS];
    logic [PW-1:0]         cell_finish[MAX_SEGMENTS];
    logic [INDEX_BITS-1:0] cell_origin[MAX_SEGMENTS];
    logic                  cell_en    [MAX_SEGMENTS];
    logic [PW-1:0]         nxt_start  [MAX_SEGMENTS];
    logic [PW-1:0]         nxt_finish [MAX_SEGMENTS];
    logic [INDEX_BITS-1:0] nxt_origin [MAX_SEGMENTS];

    state_t state_reg, state_next;
    logic [CNTB-1:0] count_reg, count_next;      // segments held
    logic [CNTB-1:0] step_reg, step_next;        // chained so far (slot i)
    logic [CNTB-1:0] cand_reg, cand_next;        // candidates scanned this step
    logic [1:0]      pair_reg, pair_next;        // pairing under evaluation
    logic [1:0]      axis_reg, axis_next;        // 0..2 issue, 3 = accumulate
    logic            overflow_reg, overflow_next;
    logic [PW-1:0]   head_reg, head_next, tail_reg, tail_next;
    logic [DW+1:0]   acc_reg, acc_next;
    logic [DW+1:0]   best_reg, best_next;
    logic [CNTB-1:0] best_cand_reg, best_cand_next;
    logic [1:0]      best_act_reg, best_act_next;
    logic            first_reg, first_next;      // first result of a chain
    logic            sq_valid_reg;
    logic [1:0]      sq_axis_reg;
    logic [INDEX_BITS-1:0] oidx_reg, oidx_next;
    logic [1:0]      oact_reg, oact_next;
    logic            odone_reg, odone_next, odrop_reg, odrop_next;
    logic            ovalid_reg, ovalid_next;
    logic [DW-1:0]   sq;

    genvar g;
    generate
        for (g = 0; g < MAX_SEGMENTS; g++)
        begin : g_cell
            gsco_cell #(.COORD_BITS(CB)) u_cell (
                .clk        (clk),
                .load_en    (cell_en[g]),
                .load_start (nxt_start[g]),
                .load_finish(nxt_finish[g]),
                .load_origin(nxt_origin[g]),
                .start_reg  (cell_start[g]),
                .finish_reg (cell_finish[g]),
                .origin_reg (cell_origin[g])
            );
        end
    endgenerate

    // Operands for the distance unit: chain end against candidate end.
    logic [PW-1:0] end_sel, cand_sel;
    logic signed [CB-1:0] op_a, op_b;
    always_comb
    begin
        end_sel  = pair_reg[0] ? head_reg : tail_reg;
        cand_sel = pair_reg[1] ? cell_finish[0] : cell_start[0];
        unique case (axis_reg)
            2'd0:    begin op_a = end_sel[CB-1:0];      op_b = cand_sel[CB-1:0]; end
            2'd1:    begin op_a = end_sel[2*CB-1:CB];   op_b = cand_sel[2*CB-1:CB]; end
            default: begin op_a = end_sel[3*CB-1:2*CB]; op_b = cand_sel[3*CB-1:2*CB]; end
        endcase
    end

    gsco_dist #(.COORD_BITS(CB)) u_dist (
        .clk   (clk),
        .a     (op_a),
        .b     (op_b),
        .sq_reg(sq)
    );

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            ovalid_reg   <= 1'b0;
            step_reg     <= '0;
            cand_reg     <= '0;
            pair_reg     <= '0;
            axis_reg     <= '0;
            first_reg    <= 1'b0;
            sq_valid_reg <= 1'b0;
            sq_axis_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
            ovalid_reg   <= ovalid_next;
            step_reg     <= step_next;
            cand_reg     <= cand_next;
            pair_reg     <= pair_next;
            axis_reg     <= axis_next;
            first_reg    <= first_next;
            sq_valid_reg <= (state_reg == ST_SCAN) && (axis_reg != 2'd3);
            sq_axis_reg  <= axis_reg;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        head_reg      <= head_next;
        tail_reg      <= tail_next;
        acc_reg       <= acc_next;
        best_reg      <= best_next;
        best_cand_reg <= best_cand_next;
        best_act_reg  <= best_act_next;
        oidx_reg      <= oidx_next;
        oact_reg      <= oact_next;
        odone_reg     <= odone_next;
        odrop_reg     <= odrop_next;
    end

    // Sequencer. During a step the unchained cells (slots 0..rem-1 of the row,
    // the chained ones are emitted and forgotten) rotate through slot 0.
    logic [CNTB-1:0] rem;
    logic            in_xfer, out_free;
    logic [DW+1:0]   total;
    logic            better;
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        overflow_next  = overflow_reg;
        step_next      = step_reg;
        cand_next      = cand_reg;
        pair_next      = pair_reg;
        axis_next      = axis_reg;
        first_next     = first_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        acc_next       = acc_reg;
        best_next      = best_reg;
        best_cand_next = best_cand_reg;
        best_act_next  = best_act_reg;
        oidx_next      = oidx_reg;
        oact_next      = oact_reg;
        odone_next     = odone_reg;
        odrop_next     = odrop_reg;
        out_free       = !ovalid_reg || out_ready;
        ovalid_next    = ovalid_reg && !out_ready;
        in_ready       = (state_reg == ST_LOAD);
        in_xfer        = in_valid && in_ready;
        rem            = count_reg - step_reg;
        total          = acc_reg + (DW+2)'(sq);
        better         = total < best_reg;
        for (int k = 0; k < MAX_SEGMENTS; k++)
        begin
            cell_en[k]    = 1'b0;
            nxt_start[k]  = cell_start[k];
            nxt_finish[k] = cell_finish[k];
            nxt_origin[k] = cell_origin[k];
        end

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_xfer)
                begin
                    if (count_reg < CNTB'(MAX_SEGMENTS))
                    begin
                        for (int k = 0; k < MAX_SEGMENTS; k++)
                        begin
                            if (CNTB'(k) == count_reg)
                            begin
                                cell_en[k]    = 1'b1;
                                nxt_start[k]  = {start_z, start_y, start_x};
                                nxt_finish[k] = {finish_z, finish_y, finish_x};
                                nxt_origin[k] = INDEX_BITS'(k);
                            end
                        end
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                    if (last_segment)
                    begin
                        state_next = ST_EMIT;
                        first_next = 1'b1;
                        step_next  = '0;
                    end
                end
            end

            ST_SCAN:
            begin
                // Axis 0..2 issue multiplies; each square arrives in the next cycle.
                if (sq_valid_reg)
                begin
                    acc_next = (sq_axis_reg == 2'd0) ? (DW+2)'(sq) : total;
                end
                if (axis_reg == 2'd3)
                begin
                    // Full distance ready in total (acc + last square).
                    if (better)
                    begin
                        best_next      = total;
                        best_cand_next = cand_reg;
                        best_act_next  = pair_reg;
                    end
                    axis_next = 2'd0;
                    pair_next = pair_reg + 1'b1;
                    if (pair_reg == ACT_REV_BOTH)
                    begin
                        // Rotate the live cells left by one.
                        for (int k = 0; k < MAX_SEGMENTS; k++)
                        begin
                            if (CNTB'(k) < rem)
                            begin
                                cell_en[k] = 1'b1;
                                if (CNTB'(k) == rem - 1'b1)
                                begin
                                    nxt_start[k]  = cell_start[0];
                                    nxt_finish[k] = cell_finish[0];
                                    nxt_origin[k] = cell_origin[0];
                                end
                                else
                                begin
                                    nxt_start[k]  = cell_start[(k+1) % MAX_SEGMENTS];
                                    nxt_finish[k] = cell_finish[(k+1) % MAX_SEGMENTS];
                                    nxt_origin[k] = cell_origin[(k+1) % MAX_SEGMENTS];
                                end
                            end
                        end
                        cand_next = cand_reg + 1'b1;
                        if (cand_reg == rem - 1'b1)
                        begin
                            // Full turn done: row is back in order.
                            state_next = ST_EMIT;
                        end
                    end
                end
                else
                begin
                    axis_next = axis_reg + 1'b1;
                end
            end

            default: // ST_EMIT
            begin
                if (out_free)
                begin
                    // Winner is at slot best_cand. Emit it, then swap it with
                    // the cell at slot 0: the later cells move down one place
                    // and the cell that led the scan fills the winner's place.
                    ovalid_next = 1'b1;
                    odrop_next  = overflow_reg;
                    if (first_reg)
                    begin
                        oidx_next = cell_origin[0];
                        oact_next = ACT_NONE;
                        head_next = cell_start[0];
                        tail_next = cell_finish[0];
                        best_cand_next = '0;
                    end
                    else
                    begin
                        oidx_next = cell_origin[SB'(best_cand_reg)];
                        oact_next = best_act_reg;
                        if (best_act_reg[0])
                            head_next = tail_reg;
                        tail_next = best_act_reg[1] ? cell_start[SB'(best_cand_reg)]
                                                    : cell_finish[SB'(best_cand_reg)];
                    end
                    for (int k = 0; k < MAX_SEGMENTS - 1; k++)
                    begin
                        cell_en[k] = 1'b1;
                        if (!first_reg && (CNTB'(k + 1) == best_cand_reg))
                        begin
                            nxt_start[k]  = cell_start[0];
                            nxt_finish[k] = cell_finish[0];
                            nxt_origin[k] = cell_origin[0];
                        end
                        else
                        begin
                            nxt_start[k]  = cell_start[k+1];
                            nxt_finish[k] = cell_finish[k+1];
                            nxt_origin[k] = cell_origin[k+1];
                        end
                    end
                    first_next = 1'b0;
                    step_next  = step_reg + 1'b1;
                    if (step_reg + 1'b1 == count_reg)
                    begin
                        odone_next    = 1'b1;
                        state_next    = ST_LOAD;
                        count_next    = '0;
                        overflow_next = 1'b0;
                    end
                    else
                    begin
                        odone_next = 1'b0;
                        state_next = ST_SCAN;
                        cand_next  = '0;
                        pair_next  = '0;
                        axis_next  = '0;
                        best_next  = '1;
                        best_cand_next = '0;
                        best_act_next  = ACT_NONE;
                    end
                end
            end
        endcase
    end

    assign out_valid     = ovalid_reg;
    assign segment_index = oidx_reg;
    assign orient_action = oact_reg;
    assign dropped_flag  = odrop_reg;
    assign chain_done    = odone_reg;

    // No item is taken while a chain is being built.
    a_no_load_while_chaining: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> !in_ready)
        else $error("input ready while chaining");

    // The count never exceeds capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNTB'(MAX_SEGMENTS))
        else $error("segment count above capacity");

    // A held result is not overwritten before transfer.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(segment_index)
                                       && $stable(orient_action)))
        else $error("result changed while stalled");

    // The last result of a chain returns the block to loading.
    a_done_returns: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(out_valid) && chain_done) |-> (state_reg == ST_LOAD))
        else $error("chain end without return to load");

endmodule

@@ sv/gsco_cell.sv @@
// One cell of the segment row: holds one segment and its load position.
// Uses gsco_pkg. Loads a new segment or another cell's contents when load_en is high.
module gsco_cell
    import gsco_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            load_en,
    input  logic signed [3*COORD_BITS-1:0] load_start,
    input  logic signed [3*COORD_BITS-1:0] load_finish,
    input  logic        [INDEX_BITS-1:0]    load_origin,
    output logic        [3*COORD_BITS-1:0] start_reg,
    output logic        [3*COORD_BITS-1:0] finish_reg,
    output logic        [INDEX_BITS-1:0]    origin_reg
);

    // Payload registers, no reset needed.
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            start_reg  <= load_start;
            finish_reg <= load_finish;
            origin_reg <= load_origin;
        end
    end

endmodule

@@ sv/gsco_dist.sv @@
// Squared distance unit: one axis per cycle, squares registered.
// Uses gsco_pkg. Squares one difference; the top level accumulates the three axes.
module gsco_dist
    import gsco_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                      clk,
    input  logic signed [COORD_BITS-1:0] a,
    input  logic signed [COORD_BITS-1:0] b,
    output logic [2*COORD_BITS+2:0]   sq_reg
);

    logic signed [COORD_BITS:0] diff;
    logic        [COORD_BITS:0] mag;

    // Absolute difference, then one multiply into a register.
    always_comb
    begin
        diff = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        mag  = diff[COORD_BITS] ? (~diff + 1'b1) : diff;
    end

    always_ff @(posedge clk)
    begin
        sq_reg <= (2*COORD_BITS+3)'(mag * mag);
    end

endmodule

@@ tb/sv/tb_greedy_segment_chain_orderer.sv @@
// Self-checking testbench for the greedy segment chain orderer.
// Depends on gsco_pkg and greedy_segment_chain_orderer; checks use a predictor or a table.
module tb_greedy_segment_chain_orderer;
    import gsco_pkg::*;

    localparam int SLOTS       = MAX_SEGMENTS_DEF;
    localparam int CB          = COORD_BITS_DEF;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int ITEM_TARGET = 470;
    localparam int HOLD_CYCLES = 1500;
    localparam int CMAX        = (1 << (CB - 1)) - 1;
    localparam int CMIN        = -(1 << (CB - 1));

    typedef struct {
        int x;
        int y;
        int z;
    } point_t;

    typedef struct {
        logic [INDEX_BITS-1:0]  idx;
        logic [ACTION_BITS-1:0] act;
        logic                   drop;
        logic                   done;
    } chain_result_t;

    typedef struct {
        point_t        s;
        point_t        f;
        bit            last;
        bit            typed;
        chain_result_t exp;
    } segment_item_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [CB-1:0] start_x, start_y, start_z;
    logic signed [CB-1:0] finish_x, finish_y, finish_z;
    logic last_segment;
    logic out_valid;
    logic out_ready;
    logic [INDEX_BITS-1:0]  segment_index;
    logic [ACTION_BITS-1:0] orient_action;
    logic dropped_flag;
    logic chain_done;

    greedy_segment_chain_orderer u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .start_x(start_x), .start_y(start_y), .start_z(start_z),
        .finish_x(finish_x), .finish_y(finish_y), .finish_z(finish_z),
        .last_segment(last_segment),
        .out_valid(out_valid), .out_ready(out_ready),
        .segment_index(segment_index), .orient_action(orient_action),
        .dropped_flag(dropped_flag), .chain_done(chain_done)
    );

    // Predictor state: the held set and the chain ends.
    point_t          held_start[SLOTS];
    point_t          held_finish[SLOTS];
    int              held_origin[SLOTS];
    int              held_count;
    bit              overflow_hit;
    chain_result_t   pending_results[$];
    segment_item_t   stim_q[$];

    int  errors;
    int  cycle_count;
    int  accepted_items;
    bit  quiet;
    bit  stim_done;
    bit  hold_done;

    // Clock and timeout.
    initial
    begin
        clk = 1'b0;
        cycle_count = 0;
        forever
        begin
            #2 clk = 1'b1;
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
            #2 clk = 1'b0;
        end
    end

    function automatic longint unsigned dist_sq(point_t a, point_t b);
        longint dx, dy, dz;
        dx = longint'(a.x) - longint'(b.x);
        dy = longint'(a.y) - longint'(b.y);
        dz = longint'(a.z) - longint'(b.z);
        return longint'(dx * dx + dy * dy + dz * dz);
    endfunction

    // Loads one segment and, on the last of a set, builds the greedy chain.
    function automatic void chain_predict(segment_item_t it, bit keep);
        point_t          head, tail, tmp_p;
        longint unsigned best_d, d;
        int              best_slot, tmp_o, n;
        logic [1:0]      best_act;
        chain_result_t   r;
        if (held_count < SLOTS)
        begin
            held_start[held_count]  = it.s;
            held_finish[held_count] = it.f;
            held_origin[held_count] = held_count;
            held_count++;
        end
        else
        begin
            overflow_hit = 1'b1;
        end
        if (!it.last)
            return;
        n = held_count;
        head = held_start[0];
        tail = held_finish[0];
        r.idx = INDEX_BITS'(held_origin[0]);
        r.act = ACT_NONE;
        r.drop = overflow_hit;
        r.done = (n == 1);
        if (keep)
            pending_results.push_back(r);
        for (int i = 1; i < n; i++)
        begin
            best_d = '1;
            best_slot = i;
            best_act = ACT_NONE;
            for (int j = i; j < n; j++)
            begin
                d = dist_sq(tail, held_start[j]);
                if (d < best_d) begin best_d = d; best_slot = j; best_act = ACT_NONE; end
                d = dist_sq(head, held_start[j]);
                if (d < best_d) begin best_d = d; best_slot = j; best_act = ACT_REV_CHAIN; end
                d = dist_sq(tail, held_finish[j]);
                if (d < best_d) begin best_d = d; best_slot = j; best_act = ACT_REV_ADDED; end
                d = dist_sq(head, held_finish[j]);
                if (d < best_d) begin best_d = d; best_slot = j; best_act = ACT_REV_BOTH; end
            end
            tmp_p = held_start[i];
            held_start[i] = held_start[best_slot];
            held_start[best_slot] = tmp_p;
            tmp_p = held_finish[i];
            held_finish[i] = held_finish[best_slot];
            held_finish[best_slot] = tmp_p;
            tmp_o = held_origin[i];
            held_origin[i] = held_origin[best_slot];
            held_origin[best_slot] = tmp_o;
            if (best_act == ACT_REV_CHAIN || best_act == ACT_REV_BOTH)
                head = tail;
            if (best_act == ACT_NONE || best_act == ACT_REV_CHAIN)
                tail = held_finish[i];
            else
                tail = held_start[i];
            r.idx = INDEX_BITS'(held_origin[i]);
            r.act = best_act;
            r.done = (i == n - 1);
            if (keep)
                pending_results.push_back(r);
        end
        held_count = 0;
        overflow_hit = 1'b0;
    endfunction

    function automatic point_t mk_point(int x, int y, int z);
        point_t p;
        p.x = x;
        p.y = y;
        p.z = z;
        return p;
    endfunction

    function automatic int rand_coord(int mode);
        case (mode)
            0: return int'($signed(CB'($urandom)));
            1: return $urandom_range(0, 127) - 64;
            2: return ($urandom_range(0, 1) != 0) ? CMAX : CMIN;
            default: return $urandom_range(0, 4095) - 2048;
        endcase
    endfunction

    function automatic point_t rand_point(int mode);
        return mk_point(rand_coord(mode), rand_coord(mode), rand_coord(mode));
    endfunction

    function automatic void add_row(point_t s, point_t f, bit last, bit typed,
                                    int idx, int drop);
        segment_item_t it;
        it.s = s;
        it.f = f;
        it.last = last;
        it.typed = typed;
        it.exp.idx = INDEX_BITS'(idx);
        it.exp.act = ACT_NONE;
        it.exp.drop = drop[0];
        it.exp.done = 1'b1;
        stim_q.push_back(it);
    endfunction

    // Directed table followed by random sets.
    task automatic build_stimulus();
        int total, set_n, mode, set_no;
        point_t a;
        // Single segments at the extremes and at zero, with the result read off directly.
        add_row(mk_point(CMAX, CMAX, CMAX), mk_point(CMIN, CMIN, CMIN), 1, 1, 0, 0);
        add_row(mk_point(CMIN, CMIN, CMIN), mk_point(CMAX, CMAX, CMAX), 1, 1, 0, 0);
        add_row(mk_point(0, 0, 0), mk_point(0, 0, 0), 1, 1, 0, 0);
        // One pair per pairing: tail-start, head-start, tail-finish, head-finish.
        add_row(mk_point(0, 0, 0), mk_point(100, 0, 0), 0, 0, 0, 0);
        add_row(mk_point(101, 0, 0), mk_point(300, 0, 0), 1, 0, 0, 0);
        add_row(mk_point(0, 0, 0), mk_point(100, 0, 0), 0, 0, 0, 0);
        add_row(mk_point(-1, 0, 0), mk_point(-300, 0, 0), 1, 0, 0, 0);
        add_row(mk_point(0, 0, 0), mk_point(100, 0, 0), 0, 0, 0, 0);
        add_row(mk_point(300, 0, 0), mk_point(101, 0, 0), 1, 0, 0, 0);
        add_row(mk_point(0, 0, 0), mk_point(100, 0, 0), 0, 0, 0, 0);
        add_row(mk_point(-300, 0, 0), mk_point(-1, 0, 0), 1, 0, 0, 0);
        // Ties: identical segments keep the earlier slot and pairing.
        a = mk_point(5, -5, 7);
        add_row(a, a, 0, 0, 0, 0);
        add_row(a, a, 0, 0, 0, 0);
        add_row(a, a, 1, 0, 0, 0);
        // Largest distances across the whole coordinate range.
        add_row(mk_point(CMIN, CMIN, CMIN), mk_point(CMIN, CMIN, CMIN), 0, 0, 0, 0);
        add_row(mk_point(CMAX, CMAX, CMAX), mk_point(CMAX, CMAX, CMAX), 0, 0, 0, 0);
        add_row(mk_point(CMIN, CMAX, CMIN), mk_point(CMAX, CMIN, CMAX), 1, 0, 0, 0);
        total = stim_q.size();
        set_no = 0;
        while (total < ITEM_TARGET)
        begin
            // Mostly small sets; one overflowing set and one full set.
            if (set_no == 3)
                set_n = SLOTS + 2;
            else if (set_no == 20)
                set_n = SLOTS;
            else
                set_n = $urandom_range(1, 8);
            mode = $urandom_range(0, 3);
            for (int k = 0; k < set_n; k++)
            begin
                if ($urandom_range(0, 3) == 0)
                    mode = $urandom_range(0, 3);
                add_row(rand_point(mode), rand_point(mode), k == set_n - 1, 0, 0, 0);
            end
            total += set_n;
            set_no++;
        end
    endtask

    // Sender: drives at the falling edge, predicts on each transfer.
    initial
    begin
        segment_item_t it;
        int gap;
        errors = 0;
        accepted_items = 0;
        quiet = 1'b0;
        stim_done = 1'b0;
        held_count = 0;
        overflow_hit = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        start_x = '0; start_y = '0; start_z = '0;
        finish_x = '0; finish_y = '0; finish_z = '0;
        last_segment = 1'b0;
        build_stimulus();
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        while (stim_q.size() > 0)
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                in_valid = 1'b0;
                gap = $urandom_range(1, 7);
                repeat (gap) @(negedge clk);
            end
            it = stim_q.pop_front();
            in_valid = 1'b1;
            start_x = CB'(it.s.x); start_y = CB'(it.s.y); start_z = CB'(it.s.z);
            finish_x = CB'(it.f.x); finish_y = CB'(it.f.y); finish_z = CB'(it.f.z);
            last_segment = it.last;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            chain_predict(it, !it.typed);
            if (it.typed)
                pending_results.push_back(it.exp);
            accepted_items++;
            if (stim_q.size() < 60)
                quiet = 1'b1;
        end
        @(negedge clk);
        in_valid = 1'b0;
        stim_done = 1'b1;
    end

    // Receiver: random stall bursts, one long hold-off to back up the input.
    initial
    begin
        int gap;
        hold_done = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && accepted_items >= 30)
            begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
                out_ready = 1'b1;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_ready = 1'b0;
                gap = $urandom_range(1, 7);
                repeat (gap - 1) @(negedge clk);
            end
            else
            begin
                out_ready = 1'b1;
            end
        end
    end

    // Result checker: compares each transfer with the oldest expectation.
    always @(posedge clk)
    begin
        chain_result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: segment_index %0d", segment_index);
                errors++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (segment_index !== e.idx)
                begin
                    $error("segment_index expected %0d actual %0d", e.idx, segment_index);
                    errors++;
                end
                if (orient_action !== e.act)
                begin
                    $error("orient_action expected %0d actual %0d", e.act, orient_action);
                    errors++;
                end
                if (dropped_flag !== e.drop)
                begin
                    $error("dropped_flag expected %0d actual %0d", e.drop, dropped_flag);
                    errors++;
                end
                if (chain_done !== e.done)
                begin
                    $error("chain_done expected %0d actual %0d", e.done, chain_done);
                    errors++;
                end
            end
        end
    end

    // End of run: drain expectations, then allow a quiet tail.
    initial
    begin
        wait (stim_done);
        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
